FILE: rtl/core/assert_macros.svh
// Assertion macros used by the scan result table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Condition that must always hold outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

FILE: rtl/core/wsrt_pkg.sv
// Types and constants of the scan result table.
package wsrt_pkg;

  localparam logic [2:0] OP_UPDATE   = 3'd0;
  localparam logic [2:0] OP_RM_BSSID = 3'd1;
  localparam logic [2:0] OP_RM_AGE   = 3'd2;
  localparam logic [2:0] OP_SET_TAGS = 3'd3;
  localparam logic [2:0] OP_CLR_TAGS = 3'd4;
  localparam logic [2:0] OP_LIST     = 3'd5;

  localparam logic [1:0] ACT_KEPT     = 2'd0;
  localparam logic [1:0] ACT_REPLACED = 2'd1;
  localparam logic [1:0] ACT_ADDED    = 2'd2;
  localparam logic [1:0] ACT_DROPPED  = 2'd3;

  localparam int unsigned MAX_OUT = 32;

  typedef struct packed {
    logic [2:0]  op;
    logic [47:0] bssid;
    logic [63:0] ssid_key;
    logic [7:0]  rcpi;
    logic        is_beacon;
    logic        band;
    logic [7:0]  channel;
    logic [15:0] record_handle;
    logic [31:0] age_limit;
    logic [7:0]  tag_mask;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] removed_count;
    logic [5:0] entry_count;
    logic       out_valid;
    logic       out_band;
    logic [7:0] out_channel;
    logic       last;
  } out_item_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [47:0] bssid;
    logic [63:0] ssid_key;
    logic [7:0]  rcpi;
    logic        beacon;
    logic        band;
    logic [7:0]  channel;
    logic [15:0] handle;
    logic [31:0] etime;
    logic [7:0]  tags;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_APPEND,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/core/wsrt_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module wsrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/wlan_scan_result_table.sv
// Top level of the scan result table: sequencer, memory and result register.
//
//   channel | ports                          | transfer when
//   input   | in_valid, in_stall, in_item    | in_valid & !in_stall
//   result  | out_valid, out_stall, out_item | out_valid & !out_stall
//
// One item walks the fill_count live entries, each read and then evaluated
// and written back, through a single memory holding whole entries. Removals
// compact in the same walk: a survivor is written at the write pointer. An
// update with no match also passes through the append state.
// Listing and the closing result wait while a result is held in the output register.
// Reset clears the state, fill_count and out_valid; entries above it are never read.
module wlan_scan_result_table
  import wsrt_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;
  in_item_t req_r, req_nxt;
  logic [CW-1:0] fill_r, fill_nxt;  // fill_count
  logic [CW-1:0] rd_r, rd_nxt;      // read pointer
  logic [CW-1:0] wr_r, wr_nxt;      // compaction write pointer
  logic [5:0] kcnt_r, kcnt_nxt;     // list results produced
  logic found_r, found_nxt;
  logic [1:0] act_r, act_nxt;
  logic out_vld_r, out_vld_nxt;
  out_item_t out_r, out_nxt;
  out_item_t held_r, held_nxt;      // newest listed entry, last bit not yet known

  logic   mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, mem_rdata;

  wsrt_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // New entry built from the request.
  entry_t fresh;
  always_comb begin
    fresh.bssid    = req_r.bssid;
    fresh.ssid_key = req_r.ssid_key;
    fresh.rcpi     = req_r.rcpi;
    fresh.beacon   = req_r.is_beacon;
    fresh.band     = req_r.band;
    fresh.channel  = req_r.channel;
    fresh.handle   = req_r.record_handle;
    fresh.etime    = req_r.now;
    fresh.tags     = '0;
  end

  logic [31:0] age_diff;
  assign age_diff = req_r.now - mem_rdata.etime;

  logic out_free;
  assign out_free = !out_vld_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      out_vld_r <= out_vld_nxt;
    end
    req_r   <= req_nxt;
    rd_r    <= rd_nxt;
    wr_r    <= wr_nxt;
    kcnt_r  <= kcnt_nxt;
    found_r <= found_nxt;
    act_r   <= act_nxt;
    out_r   <= out_nxt;
    held_r  <= held_nxt;
  end

  always_comb begin
    logic kill;
    entry_t ent;
    logic [CW-1:0] removed;
    kill = 1'b0;
    ent = mem_rdata;
    removed = '0;
    state_nxt   = state_r;
    req_nxt     = req_r;
    fill_nxt    = fill_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    kcnt_nxt    = kcnt_r;
    found_nxt   = found_r;
    act_nxt     = act_r;
    out_vld_nxt = out_vld_r && out_stall;
    out_nxt     = out_r;
    held_nxt    = held_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_r[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = rd_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_item;
          rd_nxt    = '0;
          wr_nxt    = '0;
          kcnt_nxt  = '0;
          found_nxt = 1'b0;
          act_nxt   = ACT_KEPT;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_r == fill_r) begin
          state_nxt = (req_r.op == OP_UPDATE && !found_r) ? ST_APPEND : ST_EMIT;
          fill_nxt  = wr_r;
        end else begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // mem_rdata holds entry rd_r
        unique case (req_r.op)
          OP_UPDATE: begin
            if (ent.bssid == req_r.bssid) begin
              if (ent.ssid_key == req_r.ssid_key) begin
                if (found_r) begin
                  kill = 1'b1;
                end else if (ent.tags == '0 && ent.rcpi >= req_r.rcpi) begin
                  found_nxt = 1'b1;
                  act_nxt   = ACT_KEPT;
                end else begin
                  found_nxt = 1'b1;
                  ent       = fresh;
                  act_nxt   = ACT_REPLACED;
                end
              end else if (ent.beacon && req_r.is_beacon) begin
                if (found_r) begin
                  kill = 1'b1;
                end else begin
                  found_nxt = 1'b1;
                  ent       = fresh;
                  act_nxt   = ACT_REPLACED;
                end
              end
            end
          end
          OP_RM_BSSID: kill = (ent.bssid == req_r.bssid);
          OP_RM_AGE:   kill = (age_diff > req_r.age_limit);
          OP_SET_TAGS: ent.tags = ent.tags | req_r.tag_mask;
          OP_CLR_TAGS: ent.tags = ent.tags & ~req_r.tag_mask;
          default: ;
        endcase
        if (req_r.op == OP_LIST) begin
          // a new match pushes the held one out; wait until the output register is free
          if (ent.ssid_key == req_r.ssid_key && kcnt_r < 6'(MAX_OUT)) begin
            if (out_free || kcnt_r == '0) begin
              if (kcnt_r != '0) begin
                out_vld_nxt = 1'b1;
                out_nxt     = held_r;
              end
              held_nxt             = '0;
              held_nxt.out_valid   = 1'b1;
              held_nxt.out_band    = ent.band;
              held_nxt.out_channel = ent.channel;
              held_nxt.entry_count = 6'(fill_r);
              held_nxt.last        = 1'b0;
              kcnt_nxt             = kcnt_r + 6'd1;
              rd_nxt               = rd_r + 1'b1;
              wr_nxt               = wr_r + 1'b1;
              state_nxt            = ST_READ;
            end
          end else begin
            rd_nxt    = rd_r + 1'b1;
            wr_nxt    = wr_r + 1'b1;
            state_nxt = ST_READ;
          end
        end else begin
          if (!kill) begin
            mem_we    = 1'b1;
            mem_wdata = ent;
            wr_nxt    = wr_r + 1'b1;
          end
          rd_nxt    = rd_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_APPEND: begin
        if (fill_r < CW'(DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = fill_r[AW-1:0];
          mem_wdata = fresh;
          fill_nxt  = fill_r + 1'b1;
          act_nxt   = ACT_ADDED;
        end else begin
          act_nxt   = ACT_DROPPED;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          removed     = rd_r - wr_r;
          out_vld_nxt = 1'b1;
          out_nxt     = '0;
          out_nxt.entry_count = 6'(fill_r);
          out_nxt.last        = 1'b1;
          if (req_r.op == OP_LIST) begin
            if (kcnt_r != '0) begin
              // the held entry goes out as the final transfer
              out_nxt      = held_r;
              out_nxt.last = 1'b1;
            end
          end else begin
            out_nxt.action        = (req_r.op == OP_UPDATE) ? act_r : ACT_KEPT;
            out_nxt.removed_count = 6'(removed);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The newest listed entry waits in held_r: the next match or the end of the
  // walk decides whether it carries the last bit.

  `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r <= CW'(DEPTH), "fill count exceeds depth")
  `ASSERT_ALWAYS(a_wr_le_rd, clk, rst_n, wr_r <= rd_r || state_r == ST_IDLE,
                 "compaction pointer passed read pointer")
  `ASSERT_IMPL(a_busy_stall, clk, rst_n, state_r != ST_IDLE, in_stall,
               "input taken while busy")
  `ASSERT_IMPL(a_emit_done, clk, rst_n, state_r == ST_EMIT, rd_r == wr_r ||
               req_r.op != OP_LIST, "listing changed the table")

endmodule
